>>> design/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/spq_pkg.sv
// Types and codes for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
`timescale 1ns / 1ps
package spq_pkg;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  level;
      logic [7:0]  prio;
   } entry_type;

   // request kinds carried on req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted row: compare against the new entry and shift.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_take,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output logic                  take
);

   spq_pkg::entry_type entry_ff, entry_in;

   // this slot stays ahead of the new entry (ties keep arrival order)
   assign take  = occupied && (entry_ff.prio <= ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!take) begin
            // first slot past the insert point gets the new item
            entry_in = left_take ? ctrl.new_entry : left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> design/stable_priority_queue.sv
// Top level of the stable priority queue: a row of spq_cell slots plus
// fill count and result register. Depends on spq_pkg, spq_cell, assert_macros.svh.
//
//  channel | dir | tdata                                  | tuser
//  req     | in  | tag[15:0] level[23:16] priority[31:24] | opcode[0]
//  rsp     | out | tag[15:0] level[23:16] occupancy[28:24]| status[1:0]
//
// One item per cycle unless a result stalls: every slot compares and shifts in
// parallel in the accept cycle, and the result appears in the output register
// next cycle. A stalled result holds req_tready low only while it is not taken.
// Synchronous reset empties the queue at once; slot contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // tag[15:0], level[23:16], priority[31:24]
   input  logic        req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_tag[15:0], out_level[23:16], occupancy[28:24]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type status_ff, status_in;
   logic [15:0]   tag_ff, tag_in;
   logic [7:0]    level_ff, level_in;
   logic [4:0]    occ_ff, occ_in;

   logic req_fire, is_insert, full, empty;
   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic               cell_take  [QUEUE_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_insert  = (req_tuser == spq_pkg::OP_INSERT);
   assign full       = (count_ff == DEPTH_C);
   assign empty      = (count_ff == '0);

   // broadcast command to the row
   always_comb begin
      ctrl.insert           = req_fire && is_insert && !full;
      ctrl.remove           = req_fire && !is_insert && !empty;
      ctrl.new_entry.tag    = req_tdata[15:0];
      ctrl.new_entry.level  = req_tdata[23:16];
      ctrl.new_entry.prio   = req_tdata[31:24];
   end

   // row of slots, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic               occ;
      logic               ltake;
      spq_pkg::entry_type lent, rent;
      assign occ = (CW'(i) < count_ff);
      if (i == 0) begin : g_head
         assign ltake = 1'b1;
         assign lent  = cell_entry[0];
      end else begin : g_mid
         assign ltake = cell_take[i-1];
         assign lent  = cell_entry[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign rent = cell_entry[i];
      end else begin : g_body
         assign rent = cell_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .left_take   (ltake),
         .left_entry  (lent),
         .right_entry (rent),
         .entry       (cell_entry[i]),
         .take        (cell_take[i])
      );
   end

   // count and result register
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      tag_in       = tag_ff;
      level_in     = level_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         tag_in       = '0;
         level_in     = '0;
         if (ctrl.insert) begin
            count_in  = count_ff + 1'b1;
            status_in = spq_pkg::ST_INSERTED;
         end else if (ctrl.remove) begin
            count_in  = count_ff - 1'b1;
            status_in = spq_pkg::ST_REMOVED;
            tag_in    = cell_entry[0].tag;
            level_in  = cell_entry[0].level;
         end else if (is_insert) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            status_in = spq_pkg::ST_EMPTY;
         end
         occ_in = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      tag_ff    <= tag_in;
      level_ff  <= level_in;
      occ_ff    <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ff, level_ff, tag_ff};

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   `ASSERT_NEXT(a_insert_count, clock, reset, ctrl.insert, count_ff == CW'($past(count_ff) + 1'b1))
   `ASSERT_ALWAYS(a_occ_tracks, clock, reset, !rsp_valid_ff || occ_ff == 5'(count_ff))
   `ASSERT_ALWAYS(a_full_status, clock, reset, !rsp_valid_ff || status_ff != spq_pkg::ST_FULL || full)

endmodule
